// ===== sv/hecd_pkg.sv =====
// ----------------------------------------------------------------------------
// hecd_pkg
// shared types, constants and position-mapping functions for the hamming codec
// ----------------------------------------------------------------------------
package hecd_pkg;

    localparam int CW_W     = 63;  // codeword / data word width
    localparam int LEN_W    = 6;   // length and position width
    localparam int PAR_W    = 3;   // width of a parity-bit count
    localparam int SYN_W    = 6;   // syndrome width
    localparam int DATA_MAX = 57;  // most data bits that fit in one codeword

    localparam logic MODE_ENCODE  = 1'b0;
    localparam logic MODE_CORRECT = 1'b1;

    typedef struct packed {
        logic             mode;
        logic [LEN_W-1:0] length;
        logic [CW_W-1:0]  payload;
    } t_in_word;

    typedef struct packed {
        logic [CW_W-1:0]  result_bits;
        logic [LEN_W-1:0] result_length;
        logic [SYN_W-1:0] error_position;
        logic             uncorrectable;
    } t_out_word;

    // ones in the low len bits
    function automatic logic [CW_W-1:0] len_mask(input logic [LEN_W-1:0] len);
        logic [CW_W-1:0] m;
        m = '0;
        for (int b = 0; b < CW_W; b++) begin
            if (b < int'(len)) begin
                m[b] = 1'b1;
            end
        end
        return m;
    endfunction

    // codeword positions (one-based) whose index has bit k set
    function automatic logic [CW_W-1:0] col_mask(input int k);
        logic [CW_W-1:0] m;
        m = '0;
        for (int i = 1; i <= CW_W; i++) begin
            if (((i >> k) & 1) != 0) begin
                m[i-1] = 1'b1;
            end
        end
        return m;
    endfunction

    // data bits, in order, into the non-power-of-two positions
    function automatic logic [CW_W-1:0] scatter(input logic [CW_W-1:0] data);
        logic [CW_W-1:0] cw;
        int              j;
        cw = '0;
        j  = 0;
        for (int i = 1; i <= CW_W; i++) begin
            if ((i & (i - 1)) != 0) begin
                cw[i-1] = data[j];
                j++;
            end
        end
        return cw;
    endfunction

    // non-power-of-two positions, in order, back into data bits
    function automatic logic [CW_W-1:0] gather(input logic [CW_W-1:0] cw);
        logic [CW_W-1:0] data;
        int              j;
        data = '0;
        j    = 0;
        for (int i = 1; i <= CW_W; i++) begin
            if ((i & (i - 1)) != 0) begin
                data[j] = cw[i-1];
                j++;
            end
        end
        return data;
    endfunction

    // syndrome bits into the power-of-two positions
    function automatic logic [CW_W-1:0] place_parity(input logic [SYN_W-1:0] s);
        logic [CW_W-1:0] cw;
        cw = '0;
        for (int k = 0; k < SYN_W; k++) begin
            cw[(1 << k) - 1] = s[k];
        end
        return cw;
    endfunction

    // least r with 2^r >= n + r + 1
    function automatic logic [PAR_W-1:0] parity_count(input logic [LEN_W-1:0] n);
        logic [PAR_W-1:0] r;
        r = PAR_W'(SYN_W);
        for (int k = SYN_W; k >= 0; k--) begin
            if ((1 << k) >= int'(n) + k + 1) begin
                r = PAR_W'(k);
            end
        end
        return r;
    endfunction

    // number of powers of two not above len
    function automatic logic [PAR_W-1:0] pow2_count(input logic [LEN_W-1:0] len);
        logic [PAR_W-1:0] c;
        c = '0;
        for (int k = 0; k < SYN_W; k++) begin
            if ((1 << k) <= int'(len)) begin
                c = c + PAR_W'(1);
            end
        end
        return c;
    endfunction

endpackage

// ===== sv/hamming_encode_correct_decode_core.sv =====
// ----------------------------------------------------------------------------
// hamming_encode_correct_decode_core
// variable-length hamming single-error-correcting encoder and corrector
// ----------------------------------------------------------------------------
// A word is captured in the input register, goes through the codec xor trees,
// and lands in the result register; the block takes a new word every cycle
// while the output does not stall. In encode mode up to 57 data bits (longer
// lengths saturate) are spread over the non-power-of-two positions and parity
// is placed at the powers of two; the codeword length comes back in
// result_length. In correct mode the syndrome over the first length bits names
// the bit to flip, the data bits are pulled out, and a syndrome beyond the
// length is reported with uncorrectable set and nothing flipped. Bits of the
// payload beyond length are ignored. Stall on the output backs up through both
// registers; the input keeps accepting while either register has room.
// ----------------------------------------------------------------------------
module hamming_encode_correct_decode_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input channel
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  hecd_pkg::t_in_word  i_in_data,
    // result channel
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output hecd_pkg::t_out_word o_out_data
);

    // input register stage
    logic                r_s1_valid;
    logic                n_s1_valid;
    hecd_pkg::t_in_word  r_s1_data;

    // result register stage
    logic                r_s2_valid;
    logic                n_s2_valid;
    hecd_pkg::t_out_word r_s2_data;
    hecd_pkg::t_out_word n_s2_data;

    logic                s2_load;
    logic                s1_load;

    // result register takes a new word when empty or being drained
    assign s2_load = !r_s2_valid || !i_out_stall;
    // input register takes a word when empty or moving on
    assign s1_load = !r_s1_valid || s2_load;

    // no word is taken while in reset
    assign o_in_stall = !i_rst_n || !s1_load;

    assign n_s1_valid = s1_load ? i_in_valid : r_s1_valid;
    assign n_s2_valid = s2_load ? r_s1_valid : r_s2_valid;

    // all the coding work sits between the two registers
    hecd_codec u_codec (
        .i_word (r_s1_data),
        .o_word (n_s2_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
            r_s2_valid <= n_s2_valid;
        end
    end

    // payload registers, loaded only on a live word
    always_ff @(posedge i_clk) begin
        if (s1_load && i_in_valid) begin
            r_s1_data <= i_in_data;
        end
        if (s2_load && r_s1_valid) begin
            r_s2_data <= n_s2_data;
        end
    end

    assign o_out_valid = r_s2_valid;
    assign o_out_data  = r_s2_data;

endmodule

// ===== sv/hecd_syndrome.sv =====
// ----------------------------------------------------------------------------
// hecd_syndrome
// xor trees forming the syndrome of a 63-bit codeword
// ----------------------------------------------------------------------------
module hecd_syndrome (
    input  logic [hecd_pkg::CW_W-1:0]  i_word,
    output logic [hecd_pkg::SYN_W-1:0] o_syndrome
);

    always_comb begin
        for (int k = 0; k < hecd_pkg::SYN_W; k++) begin
            o_syndrome[k] = ^(i_word & hecd_pkg::col_mask(k));
        end
    end

endmodule

// ===== sv/hecd_codec.sv =====
// ----------------------------------------------------------------------------
// hecd_codec
// one-pass encode or correct-and-extract of a single word
// ----------------------------------------------------------------------------
module hecd_codec (
    input  hecd_pkg::t_in_word  i_word,
    output hecd_pkg::t_out_word o_word
);

    logic [hecd_pkg::LEN_W-1:0] n_data;
    logic [hecd_pkg::CW_W-1:0]  cw_enc;
    logic [hecd_pkg::CW_W-1:0]  cw;
    logic [hecd_pkg::SYN_W-1:0] syn;
    logic [hecd_pkg::CW_W-1:0]  flip;
    logic                       in_range;

    // encode data count saturates so the codeword fits
    assign n_data = (i_word.length > hecd_pkg::LEN_W'(hecd_pkg::DATA_MAX))
                  ? hecd_pkg::LEN_W'(hecd_pkg::DATA_MAX) : i_word.length;

    assign cw_enc = hecd_pkg::scatter(i_word.payload & hecd_pkg::len_mask(n_data));

    assign cw = (i_word.mode == hecd_pkg::MODE_CORRECT)
              ? (i_word.payload & hecd_pkg::len_mask(i_word.length)) : cw_enc;

    hecd_syndrome u_syn (
        .i_word     (cw),
        .o_syndrome (syn)
    );

    assign in_range = (syn != '0) && (syn <= i_word.length);
    assign flip     = in_range ? (hecd_pkg::CW_W'(1) << (syn - hecd_pkg::SYN_W'(1))) : '0;

    always_comb begin
        if (i_word.mode == hecd_pkg::MODE_CORRECT) begin
            o_word.result_bits    = hecd_pkg::gather(cw ^ flip);
            o_word.result_length  = i_word.length
                                  - hecd_pkg::LEN_W'(hecd_pkg::pow2_count(i_word.length));
            o_word.error_position = syn;
            o_word.uncorrectable  = (syn != '0) && !in_range;
        end else begin
            o_word.result_bits    = cw | hecd_pkg::place_parity(syn);
            o_word.result_length  = n_data
                                  + hecd_pkg::LEN_W'(hecd_pkg::parity_count(n_data));
            o_word.error_position = '0;
            o_word.uncorrectable  = 1'b0;
        end
    end

endmodule

// ===== sv/hecd_checker.sv =====
// ----------------------------------------------------------------------------
// hecd_checker
// port-level checks on the hamming codec, bound to the top level
// ----------------------------------------------------------------------------
module hecd_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input hecd_pkg::t_in_word  i_in_data,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input hecd_pkg::t_out_word o_out_data
);

    // reset empties the result side
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a stalled result is not dropped
    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("stalled result dropped");

    // an uncorrectable word always reports a nonzero syndrome
    a_bad_has_syndrome: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.uncorrectable |-> o_out_data.error_position != '0)
        else $error("uncorrectable with zero syndrome");

    // an uncorrectable result never reports a length above the largest data length
    a_length_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.uncorrectable
            |-> o_out_data.result_length <= hecd_pkg::LEN_W'(hecd_pkg::DATA_MAX))
        else $error("result length out of range");

endmodule

bind hamming_encode_correct_decode_core hecd_checker u_hecd_checker (.*);

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the variable-length hamming encoder and corrector
// ----------------------------------------------------------------------------
// A short table of hand-picked words comes first: empty words, shortest and
// longest codes, saturated encode length, single errors on data and parity
// positions, a syndrome past the codeword length, and payload junk above the
// length. Then random words follow. Half of them are codewords built by the
// bench's own codec model, with zero, one or two bit errors injected. The
// rest are plain encodes and raw noise. Both channels idle and stall at
// random. Every result is checked field by field against the oldest pending
// expectation.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import hecd_pkg::*;

    localparam int RANDOM_WORDS = 1700;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 20;
    localparam int REPORT_MAX   = 10;
    localparam int MAX_WAIT     = 13;

    localparam logic PINNED = 1'b1;  // expected result typed into the table
    localparam logic FREE   = 1'b0;  // expected result comes from the model

    localparam logic [CW_W-1:0] ALL1   = '1;
    localparam logic [CW_W-1:0] DATA57 = 63'h01FF_FFFF_FFFF_FFFF;  // 57 data ones
    localparam t_out_word       NO_WANT = '0;

    // one row of the directed table
    typedef struct packed {
        t_in_word  word;
        logic      pinned;
        t_out_word want;
    } t_stim_row;

    // a word waiting for its result
    typedef struct {
        t_in_word  src;
        t_out_word want;
    } t_pending;

    localparam int DIRECTED_N = 24;

    // columns: mode, length, payload | pinned | bits, length, position, uncorrectable
    localparam t_stim_row DIRECTED_ROWS [DIRECTED_N] = '{
        // empty words, right after reset
        {MODE_ENCODE,  6'd0,  ALL1,   PINNED, 63'd0, 6'd0, 6'd0, 1'b0},
        {MODE_CORRECT, 6'd0,  ALL1,   PINNED, 63'd0, 6'd0, 6'd0, 1'b0},
        // shortest code: one data bit, two parity bits
        {MODE_ENCODE,  6'd1,  63'd1,  PINNED, 63'h7, 6'd3, 6'd0, 1'b0},
        // full length code, data all ones gives all ones
        {MODE_ENCODE,  6'd57, ALL1,   PINNED, ALL1,  6'd63, 6'd0, 1'b0},
        // encode length above the data limit saturates
        {MODE_ENCODE,  6'd63, ALL1,   PINNED, ALL1,  6'd63, 6'd0, 1'b0},
        {MODE_ENCODE,  6'd57, 63'd0,  PINNED, 63'd0, 6'd63, 6'd0, 1'b0},
        // clean full codeword
        {MODE_CORRECT, 6'd63, ALL1,   PINNED, DATA57, 6'd57, 6'd0, 1'b0},
        // single error on a data position
        {MODE_CORRECT, 6'd63, 63'h7FFF_FFFF_FFFF_FFEF,
                              PINNED, DATA57, 6'd57, 6'd5, 1'b0},
        // single error on the top parity position
        {MODE_CORRECT, 6'd63, 63'h7FFF_FFFF_7FFF_FFFF,
                              PINNED, DATA57, 6'd57, 6'd32, 1'b0},
        // error on the last position
        {MODE_CORRECT, 6'd63, 63'h4000_0000_0000_0000,
                              PINNED, 63'd0, 6'd57, 6'd63, 1'b0},
        // syndrome past the codeword length
        {MODE_CORRECT, 6'd4,  63'h9,  PINNED, 63'd0, 6'd1, 6'd5, 1'b1},
        // one-bit codeword with its only bit set
        {MODE_CORRECT, 6'd1,  63'h1,  PINNED, 63'd0, 6'd0, 6'd1, 1'b0},
        // junk above the length is ignored
        {MODE_ENCODE,  6'd1,  63'h7FFF_FFFF_FFFF_FFFE,
                              PINNED, 63'd0, 6'd3, 6'd0, 1'b0},
        {MODE_CORRECT, 6'd3,  63'h7FFF_FFFF_FFFF_FFF8,
                              PINNED, 63'd0, 6'd1, 6'd0, 1'b0},
        // syndrome 63 on a 40-bit word, position 31 is data bit 25
        {MODE_CORRECT, 6'd40, 63'hC000_0000,
                              PINNED, 63'h200_0000, 6'd34, 6'd63, 1'b1},
        {MODE_ENCODE,  6'd4,  63'h5A5, FREE, NO_WANT},
        {MODE_ENCODE,  6'd26, 63'h2AAA_AAAA_AAAA_AAAA, FREE, NO_WANT},
        {MODE_ENCODE,  6'd58, 63'h1234_5678_9ABC_DEF0, FREE, NO_WANT},
        // correct-mode words of assorted lengths, then two more encodes
        {MODE_CORRECT, 6'd5,  63'h1B,  FREE, NO_WANT},
        {MODE_CORRECT, 6'd12, 63'hF0,  FREE, NO_WANT},
        {MODE_CORRECT, 6'd62, ALL1,    FREE, NO_WANT},
        {MODE_CORRECT, 6'd7,  63'h7F,  FREE, NO_WANT},
        {MODE_ENCODE,  6'd11, ALL1,    FREE, NO_WANT},
        {MODE_ENCODE,  6'd32, 63'h5555_0000_FFFF_1234, FREE, NO_WANT}
    };

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_word  in_data;
    logic      out_valid;
    logic      out_stall;
    t_out_word out_data;

    // typed expectation travels with the word on the input side
    logic      tx_pinned;
    t_out_word tx_want;

    t_pending expected_words[$];
    int       mismatches;
    int       cycle_count;
    int       tx_calm;
    int       rx_calm;

    hamming_encode_correct_decode_core dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_in_data      (in_data),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_out_data     (out_data)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // positions 1, 2, 4, ... hold parity
    function automatic bit is_parity_pos(input int i);
        return i != 0 && (i & (i - 1)) == 0;
    endfunction

    // what the codec returns for one word
    function automatic t_out_word hamming_result(input t_in_word w);
        t_out_word       r;
        logic [CW_W-1:0] cw;
        logic            par;
        int              n;
        int              np;
        int              total;
        int              j;
        int              syn;
        int              len;
        r  = '0;
        cw = '0;
        j  = 0;
        if (w.mode == MODE_ENCODE) begin
            n  = (int'(w.length) > DATA_MAX) ? DATA_MAX : int'(w.length);
            np = 0;
            while ((1 << np) < n + np + 1) np++;
            total = n + np;
            for (int i = 1; i <= total; i++) begin
                if (!is_parity_pos(i)) begin
                    cw[i-1] = w.payload[j];
                    j++;
                end
            end
            // parity slots are still zero here, so each group sees only data
            for (int k = 0; k < np; k++) begin
                par = 1'b0;
                for (int i = 1; i <= total; i++) begin
                    if (((i >> k) & 1) != 0) par ^= cw[i-1];
                end
                cw[(1 << k) - 1] = par;
            end
            r.result_bits   = cw;
            r.result_length = LEN_W'(total);
        end else begin
            len = int'(w.length);
            cw  = w.payload;
            syn = 0;
            for (int i = 1; i <= len; i++) begin
                if (cw[i-1]) syn ^= i;
            end
            if (syn != 0) begin
                r.error_position = SYN_W'(syn);
                if (syn <= len) begin
                    cw[syn-1] = ~cw[syn-1];
                end else begin
                    r.uncorrectable = 1'b1;
                end
            end
            for (int i = 1; i <= len; i++) begin
                if (!is_parity_pos(i)) begin
                    r.result_bits[j] = cw[i-1];
                    j++;
                end
            end
            r.result_length = LEN_W'(j);
        end
        return r;
    endfunction

    function automatic logic [CW_W-1:0] rand_bits();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[CW_W-1:0];
    endfunction

    // idle cycles before the next word, with calm stretches of no idling
    function automatic int draw_wait(inout int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0) begin
            calm_left = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, MAX_WAIT);
    endfunction

    // starts and ends on a falling edge; valid stays high between back-to-back words
    task automatic send_word(input t_in_word w, input logic pin, input t_out_word want);
        int gap;
        gap = draw_wait(tx_calm);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        in_data   <= w;
        tx_pinned <= pin;
        tx_want   <= want;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    // result side back-pressure
    initial begin
        int hold;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever begin
            hold = draw_wait(rx_calm);
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            @(negedge clk);
        end
    end

    // both channels watched in one place so push and pop order is fixed
    always @(posedge clk) begin
        t_pending pend;
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                pend.src  = in_data;
                pend.want = tx_pinned ? tx_want : hamming_result(in_data);
                expected_words.push_back(pend);
            end
            if (out_valid && !out_stall) begin
                if (expected_words.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX) begin
                        $display("unexpected result word: bits=%h len=%0d pos=%0d unc=%0d",
                                 out_data.result_bits, out_data.result_length,
                                 out_data.error_position, out_data.uncorrectable);
                    end
                end else begin
                    pend = expected_words.pop_front();
                    if (out_data.result_bits    !== pend.want.result_bits    ||
                        out_data.result_length  !== pend.want.result_length  ||
                        out_data.error_position !== pend.want.error_position ||
                        out_data.uncorrectable  !== pend.want.uncorrectable) begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX) begin
                            $display("word mismatch: mode=%0d len=%0d payload=%h",
                                     pend.src.mode, pend.src.length, pend.src.payload);
                            $display("  expected bits=%h len=%0d pos=%0d unc=%0d",
                                     pend.want.result_bits, pend.want.result_length,
                                     pend.want.error_position, pend.want.uncorrectable);
                            $display("  actual   bits=%h len=%0d pos=%0d unc=%0d",
                                     out_data.result_bits, out_data.result_length,
                                     out_data.error_position, out_data.uncorrectable);
                        end
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        int        kind;
        int        nflip;
        int        len;
        t_in_word  w;
        t_out_word code;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        out_stall   = 1'b0;
        tx_pinned   = 1'b0;
        tx_want     = '0;
        mismatches  = 0;
        cycle_count = 0;
        tx_calm     = 0;
        rx_calm     = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed table
        for (int d = 0; d < DIRECTED_N; d++) begin
            send_word(DIRECTED_ROWS[d].word, DIRECTED_ROWS[d].pinned, DIRECTED_ROWS[d].want);
        end

        // random words, half of them real codewords with up to two injected errors
        for (int t = 0; t < RANDOM_WORDS; t++) begin
            kind      = $urandom_range(0, 9);
            w.mode    = MODE_ENCODE;
            w.length  = LEN_W'($urandom_range(1, DATA_MAX));
            w.payload = rand_bits();
            if (kind <= 2) begin
                // plain encode, now and then any length at all
                if ($urandom_range(0, 7) == 0) w.length = LEN_W'($urandom_range(0, 63));
            end else if (kind <= 7) begin
                code      = hamming_result(w);
                len       = int'(code.result_length);
                w.mode    = MODE_CORRECT;
                w.length  = code.result_length;
                w.payload = code.result_bits;
                case ($urandom_range(0, 3))
                    0: begin
                        nflip = 0;
                    end
                    3: begin
                        nflip = 2;
                    end
                    default: begin
                        nflip = 1;
                    end
                endcase
                repeat (nflip) begin
                    int pos;
                    pos = $urandom_range(1, len);
                    w.payload[pos-1] = ~w.payload[pos-1];
                end
                // junk above the codeword length
                if ($urandom_range(0, 3) == 0) begin
                    w.payload |= rand_bits() & ~((CW_W'(1) << len) - CW_W'(1));
                end
            end else begin
                // raw noise over every field
                w.mode    = 1'($urandom_range(0, 1));
                w.length  = LEN_W'($urandom_range(0, 63));
                w.payload = rand_bits();
            end
            send_word(w, FREE, NO_WANT);
        end
        in_valid <= 1'b0;

        while (expected_words.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_words.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/hecd_pkg.sv
sv/hecd_syndrome.sv
sv/hecd_codec.sv
sv/hamming_encode_correct_decode_core.sv
sv/hecd_checker.sv
tb/testbench.sv
